// ===== rtl/sct_pkg.sv =====
// Shared types, constants and helpers for the degree-input sine/cosine Taylor pipeline.
package sct_pkg;

    // Field formats
    localparam int IN_FRAC_BITS  = 8;
    localparam int OUT_FRAC_BITS = 16;
    localparam int ANGLE_W       = 18;
    localparam int RES_W         = 24;
    localparam int WF            = 24;   // working fraction bits

    // Degrees to radians: a = round(mag * pi / 180) with pi held at 40 fraction bits
    localparam logic [63:0] PI_Q40  = 64'h0000_0324_3F6A_8886;
    localparam int          MAG_W   = ANGLE_W;
    localparam int          DEN_SH  = IN_FRAC_BITS + 40 - WF;
    localparam logic [63:0] RAD_DEN = 64'd180 << DEN_SH;
    // pi_q40 = K * den + R, so a = mag*K + floor((mag*R + den/2) / den)
    localparam int K_W  = WF - IN_FRAC_BITS - 5;
    localparam int R_W  = DEN_SH + 8;
    localparam int X_W  = MAG_W + R_W;
    localparam int Y_W  = MAG_W + 7;
    localparam int MY_S = Y_W + 8;
    localparam int MY_W = Y_W + 1;
    localparam int Q_W  = MAG_W;
    localparam int A_W  = MAG_W + K_W - 1;

    localparam logic [K_W-1:0]  RAD_K    = K_W'(PI_Q40 / RAD_DEN);
    localparam logic [R_W-1:0]  RAD_R    = R_W'(PI_Q40 % RAD_DEN);
    localparam logic [X_W-1:0]  RAD_HALF = X_W'(RAD_DEN >> 1);
    localparam logic [MY_W-1:0] RAD_MY   = MY_W'(((64'd1 << MY_S) + 64'd179) / 64'd180);

    // Term recurrence widths (terms stay below 2^10 in value for any 18-bit angle)
    localparam int T_W   = 34;
    localparam int ACC_W = T_W + 4;
    localparam int V_W   = T_W + A_W - WF;
    localparam int VL_W  = 18;
    localparam int VH_W  = V_W - VL_W;
    localparam int KQ_W  = 4;
    localparam int RH_S  = VH_W + KQ_W;
    localparam int M1_W  = RH_S;
    localparam int W_W   = VL_W + KQ_W;
    localparam int RL_S  = W_W + KQ_W;
    localparam int M2_W  = RL_S;
    localparam int FIRST_K = 2;
    localparam int LAST_K  = 9;

    // Output conversion
    localparam int OUT_SH = WF - OUT_FRAC_BITS;
    localparam logic [ACC_W:0] ROUND_HALF = (ACC_W+1)'((64'd1 << OUT_SH) >> 1);
    localparam logic [ACC_W:0] RES_MAXP   = (ACC_W+1)'((64'd1 << (RES_W - 1)) - 64'd1);
    localparam logic [ACC_W:0] RES_MAXN   = (ACC_W+1)'(64'd1 << (RES_W - 1));
    localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(64'd1 << WF);

    // Exact angles with fixed answers
    localparam logic [ANGLE_W-1:0] ANG_0   = '0;
    localparam logic [ANGLE_W-1:0] ANG_90  = ANGLE_W'(64'd90 << IN_FRAC_BITS);
    localparam logic [ANGLE_W-1:0] ANG_180 = ANGLE_W'(64'd180 << IN_FRAC_BITS);
    localparam logic [ANGLE_W-1:0] ANG_270 = ANGLE_W'(64'd270 << IN_FRAC_BITS);
    localparam logic [ANGLE_W-1:0] ANG_360 = ANGLE_W'(64'd360 << IN_FRAC_BITS);

    typedef enum logic [2:0] {
        SPEC_NONE,
        SPEC_ZERO,
        SPEC_90,
        SPEC_180,
        SPEC_270
    } t_spec;

    // Payload carried down the pipeline with each request
    typedef struct packed {
        logic [A_W-1:0]          a;
        logic [T_W-1:0]          t;
        logic signed [ACC_W-1:0] acc_s;
        logic signed [ACC_W-1:0] acc_c;
        logic                    neg;
        t_spec                   spec;
    } t_work;

    // Add or subtract term number j into the sine (odd j) or cosine (even j) sum
    function automatic t_work fold(input t_work w, input logic [KQ_W-1:0] j);
        t_work                   r;
        logic signed [ACC_W-1:0] term;
        r    = w;
        term = signed'({{(ACC_W-T_W){1'b0}}, w.t});
        if (j[0]) begin
            r.acc_s = j[1] ? w.acc_s - term : w.acc_s + term;
        end else begin
            r.acc_c = j[1] ? w.acc_c - term : w.acc_c + term;
        end
        return r;
    endfunction

    // ceil(2^s / k) for the small divisors of the series
    function automatic logic [63:0] recip(input logic [KQ_W-1:0] k, input int unsigned s);
        logic [63:0] r;
        unique case (k)
            4'd2:    r = ((64'd1 << s) + 64'd1) / 64'd2;
            4'd3:    r = ((64'd1 << s) + 64'd2) / 64'd3;
            4'd4:    r = ((64'd1 << s) + 64'd3) / 64'd4;
            4'd5:    r = ((64'd1 << s) + 64'd4) / 64'd5;
            4'd6:    r = ((64'd1 << s) + 64'd5) / 64'd6;
            4'd7:    r = ((64'd1 << s) + 64'd6) / 64'd7;
            4'd8:    r = ((64'd1 << s) + 64'd7) / 64'd8;
            4'd9:    r = ((64'd1 << s) + 64'd8) / 64'd9;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/sct_rad.sv =====
// Angle decode and degree-to-radian conversion, three register stages.
module sct_rad (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [sct_pkg::ANGLE_W-1:0]  i_angle,
    output logic                                o_valid,
    output sct_pkg::t_work                      o_work
);

    // Stage 1: sign, magnitude, exact-angle detect
    logic [sct_pkg::MAG_W-1:0] n_mag;
    sct_pkg::t_spec            n_spec;
    logic                      r1_valid;
    logic [sct_pkg::MAG_W-1:0] r1_mag;
    logic                      r1_neg;
    sct_pkg::t_spec            r1_spec;

    always_comb begin
        n_mag = i_angle[sct_pkg::ANGLE_W-1] ? sct_pkg::MAG_W'(-i_angle)
                                            : sct_pkg::MAG_W'(i_angle);
        unique case (i_angle)
            sct_pkg::ANG_0, sct_pkg::ANG_360: n_spec = sct_pkg::SPEC_ZERO;
            sct_pkg::ANG_90:                  n_spec = sct_pkg::SPEC_90;
            sct_pkg::ANG_180:                 n_spec = sct_pkg::SPEC_180;
            sct_pkg::ANG_270:                 n_spec = sct_pkg::SPEC_270;
            default:                          n_spec = sct_pkg::SPEC_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag  <= n_mag;
            r1_neg  <= i_angle[sct_pkg::ANGLE_W-1];
            r1_spec <= n_spec;
        end
    end

    // Stage 2: integer part mag*K and remainder product mag*R + den/2
    logic [sct_pkg::MAG_W+sct_pkg::K_W-1:0] n_mk;
    logic [sct_pkg::X_W-1:0]                n_x;
    logic                                   r2_valid;
    logic [sct_pkg::A_W-1:0]                r2_mk;
    logic [sct_pkg::Y_W-1:0]                r2_y;
    logic                                   r2_neg;
    sct_pkg::t_spec                         r2_spec;

    assign n_mk = {{sct_pkg::K_W{1'b0}}, r1_mag} * {{sct_pkg::MAG_W{1'b0}}, sct_pkg::RAD_K};
    assign n_x  = {{sct_pkg::R_W{1'b0}}, r1_mag} * {{sct_pkg::MAG_W{1'b0}}, sct_pkg::RAD_R}
                + sct_pkg::RAD_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_mk   <= n_mk[sct_pkg::A_W-1:0];
            r2_y    <= n_x[sct_pkg::DEN_SH +: sct_pkg::Y_W];
            r2_neg  <= r1_neg;
            r2_spec <= r1_spec;
        end
    end

    // Stage 3: divide by 180 through the reciprocal, form a and seed the sums
    logic [sct_pkg::Y_W+sct_pkg::MY_W-1:0] n_py;
    logic [sct_pkg::A_W-1:0]               n_a;
    logic                                  r3_valid;
    sct_pkg::t_work                        r3_work;

    assign n_py = {{sct_pkg::MY_W{1'b0}}, r2_y} * {{sct_pkg::Y_W{1'b0}}, sct_pkg::RAD_MY};
    assign n_a  = r2_mk + sct_pkg::A_W'(n_py[sct_pkg::MY_S +: sct_pkg::Q_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_work.a     <= n_a;
            r3_work.t     <= {{(sct_pkg::T_W-sct_pkg::A_W){1'b0}}, n_a};
            r3_work.acc_s <= '0;
            r3_work.acc_c <= sct_pkg::ACC_ONE;
            r3_work.neg   <= r2_neg;
            r3_work.spec  <= r2_spec;
        end
    end

    assign o_valid = r3_valid;
    assign o_work  = r3_work;

endmodule

// ===== rtl/sct_term.sv =====
// One series step: folds term k-1 into its sum and forms t(k) = floor(t(k-1)*a / 2^WF / k).
module sct_term (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [sct_pkg::KQ_W-1:0]   i_k,
    input  logic                       i_valid,
    input  sct_pkg::t_work             i_work,
    output logic                       o_valid,
    output sct_pkg::t_work             o_work
);

    // Stage M: product t*a, and accumulate the previous term
    logic [sct_pkg::T_W+sct_pkg::A_W-1:0] n_prod;
    logic                                 rm_valid;
    logic [sct_pkg::V_W-1:0]              rm_v;
    sct_pkg::t_work                       rm_work;

    assign n_prod = {{sct_pkg::A_W{1'b0}}, i_work.t} * {{sct_pkg::T_W{1'b0}}, i_work.a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_valid <= 1'b0;
        end else if (i_en) begin
            rm_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rm_v    <= n_prod[sct_pkg::WF +: sct_pkg::V_W];
            rm_work <= sct_pkg::fold(i_work, i_k - sct_pkg::KQ_W'(1));
        end
    end

    // Stage D1: high-half quotient by reciprocal
    logic [sct_pkg::M1_W-1:0]             m1;
    logic [sct_pkg::VH_W+sct_pkg::M1_W-1:0] n_p1;
    logic                                 rd1_valid;
    logic [sct_pkg::VH_W-1:0]             rd1_qh;
    logic [sct_pkg::VH_W-1:0]             rd1_vh;
    logic [sct_pkg::VL_W-1:0]             rd1_vl;
    sct_pkg::t_work                       rd1_work;

    assign m1   = sct_pkg::M1_W'(sct_pkg::recip(i_k, sct_pkg::RH_S));
    assign n_p1 = {{sct_pkg::M1_W{1'b0}}, rm_v[sct_pkg::VL_W +: sct_pkg::VH_W]}
                * {{sct_pkg::VH_W{1'b0}}, m1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd1_valid <= 1'b0;
        end else if (i_en) begin
            rd1_valid <= rm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rd1_qh   <= n_p1[sct_pkg::RH_S +: sct_pkg::VH_W];
            rd1_vh   <= rm_v[sct_pkg::VL_W +: sct_pkg::VH_W];
            rd1_vl   <= rm_v[sct_pkg::VL_W-1:0];
            rd1_work <= rm_work;
        end
    end

    // Stage D2: high-half remainder
    logic [sct_pkg::VH_W+sct_pkg::KQ_W-1:0] n_qk;
    logic [sct_pkg::VH_W-1:0]               n_rh;
    logic                                   rd2_valid;
    logic [sct_pkg::KQ_W-1:0]               rd2_rh;
    logic [sct_pkg::VH_W-1:0]               rd2_qh;
    logic [sct_pkg::VL_W-1:0]               rd2_vl;
    sct_pkg::t_work                         rd2_work;

    assign n_qk = {{sct_pkg::KQ_W{1'b0}}, rd1_qh} * {{sct_pkg::VH_W{1'b0}}, i_k};
    assign n_rh = rd1_vh - n_qk[sct_pkg::VH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd2_valid <= 1'b0;
        end else if (i_en) begin
            rd2_valid <= rd1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rd2_rh   <= n_rh[sct_pkg::KQ_W-1:0];
            rd2_qh   <= rd1_qh;
            rd2_vl   <= rd1_vl;
            rd2_work <= rd1_work;
        end
    end

    // Stage D3: low-half quotient, remainder below k so it fits VL_W bits
    logic [sct_pkg::M2_W-1:0]              m2;
    logic [sct_pkg::W_W-1:0]               w_low;
    logic [sct_pkg::W_W+sct_pkg::M2_W-1:0] n_p2;
    sct_pkg::t_work                        n_work;
    logic                                  rd3_valid;
    sct_pkg::t_work                        rd3_work;

    assign m2    = sct_pkg::M2_W'(sct_pkg::recip(i_k, sct_pkg::RL_S));
    assign w_low = {rd2_rh, rd2_vl};
    assign n_p2  = {{sct_pkg::M2_W{1'b0}}, w_low} * {{sct_pkg::W_W{1'b0}}, m2};

    always_comb begin
        n_work   = rd2_work;
        n_work.t = {rd2_qh[sct_pkg::T_W-sct_pkg::VL_W-1:0],
                    n_p2[sct_pkg::RL_S +: sct_pkg::VL_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd3_valid <= 1'b0;
        end else if (i_en) begin
            rd3_valid <= rd2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rd3_work <= n_work;
        end
    end

    assign o_valid = rd3_valid;
    assign o_work  = rd3_work;

endmodule

// ===== rtl/sct_out.sv =====
// Final term fold, exact-angle override, rounding, saturation and the output register.
module sct_out (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  sct_pkg::t_work                    i_work,
    output logic                              o_valid,
    output logic signed [sct_pkg::RES_W-1:0]  o_sine_value,
    output logic signed [sct_pkg::RES_W-1:0]  o_cosine_value
);

    // Stage 1: last sine term, then fixed answers for exact angles
    sct_pkg::t_work                   n_fold;
    logic signed [sct_pkg::ACC_W-1:0] n_s;
    logic signed [sct_pkg::ACC_W-1:0] n_c;
    logic                             r1_valid;
    logic signed [sct_pkg::ACC_W-1:0] r1_s;
    logic signed [sct_pkg::ACC_W-1:0] r1_c;
    logic                             r1_neg;

    always_comb begin
        n_fold = sct_pkg::fold(i_work, sct_pkg::KQ_W'(sct_pkg::LAST_K));
        unique case (i_work.spec)
            sct_pkg::SPEC_ZERO: begin
                n_s = '0;
                n_c = sct_pkg::ACC_ONE;
            end
            sct_pkg::SPEC_90: begin
                n_s = sct_pkg::ACC_ONE;
                n_c = '0;
            end
            sct_pkg::SPEC_180: begin
                n_s = '0;
                n_c = -sct_pkg::ACC_ONE;
            end
            sct_pkg::SPEC_270: begin
                n_s = -sct_pkg::ACC_ONE;
                n_c = '0;
            end
            default: begin
                n_s = n_fold.acc_s;
                n_c = n_fold.acc_c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_s   <= n_s;
            r1_c   <= n_c;
            r1_neg <= i_work.neg;
        end
    end

    // Stage 2: sign and magnitude; a negative angle flips the sine sign
    logic                           r2_valid;
    logic                           r2_s_sgn;
    logic                           r2_c_sgn;
    logic [sct_pkg::ACC_W-1:0]      r2_s_mag;
    logic [sct_pkg::ACC_W-1:0]      r2_c_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_s_sgn <= r1_s[sct_pkg::ACC_W-1] ^ r1_neg;
            r2_c_sgn <= r1_c[sct_pkg::ACC_W-1];
            r2_s_mag <= r1_s[sct_pkg::ACC_W-1] ? sct_pkg::ACC_W'(-r1_s)
                                               : sct_pkg::ACC_W'(r1_s);
            r2_c_mag <= r1_c[sct_pkg::ACC_W-1] ? sct_pkg::ACC_W'(-r1_c)
                                               : sct_pkg::ACC_W'(r1_c);
        end
    end

    // Stage 3: round half away from zero, clamp to the output range
    logic [sct_pkg::ACC_W:0]   n_s_rnd;
    logic [sct_pkg::ACC_W:0]   n_c_rnd;
    logic [sct_pkg::ACC_W:0]   n_s_lim;
    logic [sct_pkg::ACC_W:0]   n_c_lim;
    logic [sct_pkg::ACC_W:0]   n_s_sat;
    logic [sct_pkg::ACC_W:0]   n_c_sat;
    logic                      r3_valid;
    logic                      r3_s_sgn;
    logic                      r3_c_sgn;
    logic [sct_pkg::RES_W-1:0] r3_s_mag;
    logic [sct_pkg::RES_W-1:0] r3_c_mag;

    always_comb begin
        n_s_rnd = ({1'b0, r2_s_mag} + sct_pkg::ROUND_HALF) >> sct_pkg::OUT_SH;
        n_c_rnd = ({1'b0, r2_c_mag} + sct_pkg::ROUND_HALF) >> sct_pkg::OUT_SH;
        n_s_lim = r2_s_sgn ? sct_pkg::RES_MAXN : sct_pkg::RES_MAXP;
        n_c_lim = r2_c_sgn ? sct_pkg::RES_MAXN : sct_pkg::RES_MAXP;
        n_s_sat = (n_s_rnd > n_s_lim) ? n_s_lim : n_s_rnd;
        n_c_sat = (n_c_rnd > n_c_lim) ? n_c_lim : n_c_rnd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_s_sgn <= r2_s_sgn;
            r3_c_sgn <= r2_c_sgn;
            r3_s_mag <= n_s_sat[sct_pkg::RES_W-1:0];
            r3_c_mag <= n_c_sat[sct_pkg::RES_W-1:0];
        end
    end

    // Stage 4: apply sign into the output register
    logic                             r4_valid;
    logic signed [sct_pkg::RES_W-1:0] r4_sine;
    logic signed [sct_pkg::RES_W-1:0] r4_cosine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_sine   <= r3_s_sgn ? signed'(-r3_s_mag) : signed'(r3_s_mag);
            r4_cosine <= r3_c_sgn ? signed'(-r3_c_mag) : signed'(r3_c_mag);
        end
    end

    assign o_valid        = r4_valid;
    assign o_sine_value   = r4_sine;
    assign o_cosine_value = r4_cosine;

endmodule

// ===== rtl/sin_cos_taylor_degrees.sv =====
// Top level: sine and cosine of an angle in degrees by a pipelined Taylor series.
//
//   channel   direction  handshake          payload
//   request   in         i_valid / o_stall  i_angle_deg   s18, 8 fraction bits
//   result    out        o_valid / i_stall  o_sine_value, o_cosine_value  s24, 16 fraction bits
//
// One request enters per cycle while no result is held by i_stall; a request passes
// 3 radian-conversion stages, 4 stages per series term k = 2..9 and 4 output stages.
// The term recurrence sets the depth: each term is a multiply then a three-step
// divide by k. Reset clears only the valid bits; no state survives between requests.
// A stall on the result side with a result waiting freezes every stage at once,
// and o_stall follows so no request is taken or dropped.
module sin_cos_taylor_degrees (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [sct_pkg::ANGLE_W-1:0] i_angle_deg,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [sct_pkg::RES_W-1:0]  o_sine_value,
    output logic signed [sct_pkg::RES_W-1:0]  o_cosine_value
);

    // Global advance: hold everything only while a finished result is refused
    logic en;
    assign en      = ~(o_valid & i_stall);
    assign o_stall = o_valid & i_stall;

    // Chain between stages, index = number of the last term produced
    logic           v_chain [sct_pkg::FIRST_K-1:sct_pkg::LAST_K];
    sct_pkg::t_work w_chain [sct_pkg::FIRST_K-1:sct_pkg::LAST_K];

    sct_rad u_rad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_angle (i_angle_deg),
        .o_valid (v_chain[sct_pkg::FIRST_K-1]),
        .o_work  (w_chain[sct_pkg::FIRST_K-1])
    );

    // One step per series term
    for (genvar gk = sct_pkg::FIRST_K; gk <= sct_pkg::LAST_K; gk++) begin : g_term
        sct_term u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_k     (sct_pkg::KQ_W'(gk)),
            .i_valid (v_chain[gk-1]),
            .i_work  (w_chain[gk-1]),
            .o_valid (v_chain[gk]),
            .o_work  (w_chain[gk])
        );
    end

    sct_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (v_chain[sct_pkg::LAST_K]),
        .i_work         (w_chain[sct_pkg::LAST_K]),
        .o_valid        (o_valid),
        .o_sine_value   (o_sine_value),
        .o_cosine_value (o_cosine_value)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the degree-input sine/cosine Taylor pipeline.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned t_u64;

    typedef struct {
        logic signed [sct_pkg::RES_W-1:0] sine;
        logic signed [sct_pkg::RES_W-1:0] cosine;
    } t_trig_pair;

    // Radian conversion and series constants
    localparam t_u64 RAD_PI      = 64'h0000_0324_3F6A_8886;  // pi at 40 fraction bits
    localparam int   FRAC_IN     = 8;
    localparam int   FRAC_WORK   = 24;
    localparam int   FRAC_OUT    = 16;
    localparam t_u64 TERM_LIMIT  = 64'd1 << 44;
    localparam t_u64 OUT_MAX_POS = (64'd1 << 23) - 64'd1;
    localparam t_u64 OUT_MAX_NEG = 64'd1 << 23;
    localparam int   DEG_90      = 90 << FRAC_IN;

    // Idle and stall schedule, by requests accepted so far, and run length
    localparam int PHASE_A_END = 600;
    localparam int PHASE_B_END = 1200;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 250;
    localparam int RANDOM_REQS = 1750;
    localparam int DRAIN_WAIT  = 80;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                req_valid = 1'b0;
    logic                                req_stall;
    logic signed [sct_pkg::ANGLE_W-1:0]  req_angle = '0;
    logic                                res_valid;
    logic                                res_stall = 1'b0;
    logic signed [sct_pkg::RES_W-1:0]    res_sine;
    logic signed [sct_pkg::RES_W-1:0]    res_cosine;

    logic [sct_pkg::ANGLE_W-1:0] angle_pending [$];
    t_trig_pair                  expected_pairs [$];
    int                          n_sent = 0;
    int                          n_errors = 0;
    int                          hold_left = 0;
    logic                        hold_done = 1'b0;

    sin_cos_taylor_degrees u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (req_valid),
        .o_stall        (req_stall),
        .i_angle_deg    (req_angle),
        .o_valid        (res_valid),
        .i_stall        (res_stall),
        .o_sine_value   (res_sine),
        .o_cosine_value (res_cosine)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Round a working-format sum to the output format and saturate
    function automatic logic [sct_pkg::RES_W-1:0] round_to_out(input longint v);
        logic neg;
        t_u64 m;
        neg = v < 0;
        m   = neg ? t_u64'(-v) : t_u64'(v);
        m   = (m + (t_u64'(1) << (FRAC_WORK - FRAC_OUT - 1))) >> (FRAC_WORK - FRAC_OUT);
        if (!neg && m > OUT_MAX_POS) m = OUT_MAX_POS;
        if (neg && m > OUT_MAX_NEG) m = OUT_MAX_NEG;
        return neg ? sct_pkg::RES_W'(t_u64'(0) - m) : sct_pkg::RES_W'(m);
    endfunction

    // Expected sine and cosine of one angle
    function automatic t_trig_pair predict_sin_cos(input logic [sct_pkg::ANGLE_W-1:0] raw);
        t_trig_pair r;
        logic       neg;
        t_u64       mag, den, a, q;
        t_u64       term [10];
        longint     one, s, c;
        neg = raw[sct_pkg::ANGLE_W-1];
        mag = neg ? (t_u64'(1) << sct_pkg::ANGLE_W) - t_u64'(raw) : t_u64'(raw);
        one = longint'(1) << FRAC_WORK;
        if (raw == 0 || raw == 4 * DEG_90) begin
            s = 0;
            c = one;
        end else if (raw == DEG_90) begin
            s = one;
            c = 0;
        end else if (raw == 2 * DEG_90) begin
            s = 0;
            c = -one;
        end else if (raw == 3 * DEG_90) begin
            s = -one;
            c = 0;
        end else begin
            den     = t_u64'(180) << (FRAC_IN + 40 - FRAC_WORK);
            a       = (mag * RAD_PI + (den >> 1)) / den;
            term[0] = t_u64'(1) << FRAC_WORK;
            term[1] = a;
            // each term from the one before, clamped when it blows up
            for (int k = 2; k <= 9; k++) begin
                if (a != 0 && term[k-1] > 64'hFFFF_FFFF_FFFF_FFFF / a) begin
                    term[k] = TERM_LIMIT;
                end else begin
                    q       = ((term[k-1] * a) >> FRAC_WORK) / t_u64'(k);
                    term[k] = q > TERM_LIMIT ? TERM_LIMIT : q;
                end
            end
            s = longint'(term[1]) - longint'(term[3]) + longint'(term[5])
                - longint'(term[7]) + longint'(term[9]);
            if (neg) s = -s;
            c = one - longint'(term[2]) + longint'(term[4])
                - longint'(term[6]) + longint'(term[8]);
        end
        r.sine   = round_to_out(s);
        r.cosine = round_to_out(c);
        return r;
    endfunction

    // Request driver: takes the next angle when the slot is free, idles at random
    always @(posedge clk) begin : driver
        int unsigned idle_pct;
        idle_pct = (n_sent < PHASE_A_END) ? 32 : (n_sent < PHASE_B_END) ? 77 : 0;
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && !req_stall) begin
                expected_pairs.push_back(predict_sin_cos(req_angle));
                n_sent <= n_sent + 1;
            end
            if (!req_valid || !req_stall) begin
                // keep offering during the long hold so the pipeline backs up
                if (angle_pending.size() != 0 &&
                    (hold_left != 0 || $urandom_range(99) >= idle_pct)) begin
                    req_angle <= angle_pending.pop_front();
                    req_valid <= 1'b1;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random stall plus one long hold, checks each result
    always @(posedge clk) begin : monitor
        int unsigned stall_pct;
        t_trig_pair  exp_pair;
        stall_pct = (n_sent < PHASE_A_END) ? 77 : (n_sent < PHASE_B_END) ? 32 : 0;
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else begin
            if (!hold_done && n_sent >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                res_stall <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                res_stall <= 1'b1;
            end else begin
                res_stall <= ($urandom_range(99) < stall_pct);
            end

            if (res_valid && !res_stall) begin
                if (expected_pairs.size() == 0) begin
                    $error("unexpected result: sine %0d cosine %0d", res_sine, res_cosine);
                    n_errors = n_errors + 1;
                end else begin
                    exp_pair = expected_pairs.pop_front();
                    if (res_sine !== exp_pair.sine) begin
                        $error("sine_value: expected %0d, got %0d", exp_pair.sine, res_sine);
                        n_errors = n_errors + 1;
                    end
                    if (res_cosine !== exp_pair.cosine) begin
                        $error("cosine_value: expected %0d, got %0d",
                               exp_pair.cosine, res_cosine);
                        n_errors = n_errors + 1;
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int                          pick;
        int                          mult;
        logic [sct_pkg::ANGLE_W-1:0] ang;

        // exact angles, their negatives, near misses and field extremes
        angle_pending.push_back(18'(0));
        for (int m = 1; m <= 4; m++) begin
            angle_pending.push_back(18'(m * DEG_90));
            angle_pending.push_back(18'(-m * DEG_90));
        end
        angle_pending.push_back(18'(1));
        angle_pending.push_back(18'(-1));
        angle_pending.push_back(18'(DEG_90 + 1));
        angle_pending.push_back(18'(DEG_90 - 1));
        angle_pending.push_back(18'(4 * DEG_90 - 1));
        angle_pending.push_back(18'(-(4 * DEG_90 - 1)));
        angle_pending.push_back(18'(131071));
        angle_pending.push_back(18'(-131072));
        angle_pending.push_back(18'(87381));
        angle_pending.push_back(18'(-87382));
        angle_pending.push_back(18'(256));
        angle_pending.push_back(18'(7680));
        angle_pending.push_back(18'(15360));
        angle_pending.push_back(18'(DEG_90 / 2));
        angle_pending.push_back(18'(-(DEG_90 / 2)));

        // random angles: mostly in range, some exact or near exact, some any pattern
        for (int n = 0; n < RANDOM_REQS; n++) begin
            pick = $urandom_range(99);
            mult = int'($urandom_range(8)) - 4;
            if (pick < 10) begin
                ang = 18'(mult * DEG_90);
            end else if (pick < 15) begin
                ang = 18'(mult * DEG_90 + ($urandom_range(1) ? 1 : -1));
            end else if (pick < 30) begin
                ang = 18'($urandom);
            end else begin
                ang = 18'(int'($urandom_range(8 * DEG_90)) - 4 * DEG_90);
            end
            angle_pending.push_back(ang);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (angle_pending.size() != 0 || req_valid || expected_pairs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sct_pkg.sv
rtl/sct_rad.sv
rtl/sct_term.sv
rtl/sct_out.sv
rtl/sin_cos_taylor_degrees.sv
tb/tb.sv
